// ===== sv/assert_macros.svh =====
// Assertion helpers for the ordered list engine.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define OLE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ordered list engine check failed");
`define OLE_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordered list engine check failed");
`else
`define OLE_ASSERT(name, prop)
`define OLE_ASSERT_IMPL(name, ante, cons)
`endif
`endif

// ===== sv/olist_pkg.sv =====
`timescale 1ns / 1ps
package olist_pkg;

  localparam int unsigned POS_W  = 11;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned DATA_W = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BEYOND = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] upper_bound;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  found_position;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // what each cell does this cycle, relative to the broadcast index
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LEFT,   // below index: take right neighbor; at index: take data
    CELL_RIGHT   // above index: take left neighbor; at index: take data
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e        mode;
    logic [DATA_W-1:0] data;
  } cell_ctrl_t;

endpackage

// ===== sv/olist_cell.sv =====
`timescale 1ns / 1ps
module olist_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IW    = 10
) (
  input  logic                            clk_i,
  input  olist_pkg::cell_ctrl_t           ctrl_i,
  input  logic [IW-1:0]                   idx_i,
  input  logic [olist_pkg::DATA_W-1:0]    left_i,
  input  logic [olist_pkg::DATA_W-1:0]    right_i,
  output logic [olist_pkg::DATA_W-1:0]    data_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [olist_pkg::DATA_W-1:0] data_q;
  logic [olist_pkg::DATA_W-1:0] data_d;
  logic                         below;
  logic                         here;

  assign below = MY_IDX < idx_i;
  assign here  = MY_IDX == idx_i;

  // pick the next entry from a neighbor, the broadcast data, or hold
  always_comb begin
    data_d = data_q;
    case (ctrl_i.mode)
      olist_pkg::CELL_LEFT: begin
        if (below) begin
          data_d = right_i;
        end else if (here) begin
          data_d = ctrl_i.data;
        end
      end
      olist_pkg::CELL_RIGHT: begin
        if (here) begin
          data_d = ctrl_i.data;
        end else if (!below) begin
          data_d = left_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== sv/olist_chain.sv =====
`timescale 1ns / 1ps
module olist_chain #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned IW       = 10
) (
  input  logic                         clk_i,
  input  olist_pkg::cell_ctrl_t        ctrl_i,
  input  logic [IW-1:0]                idx_i,
  output logic [olist_pkg::DATA_W-1:0] head_o
);

  logic [olist_pkg::DATA_W-1:0] cell_q [CAPACITY];

  // row of cells; the two ends see the broadcast data as their outer neighbor
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [olist_pkg::DATA_W-1:0] left_w;
    logic [olist_pkg::DATA_W-1:0] right_w;

    if (k == 0) begin : g_first
      assign left_w = ctrl_i.data;
    end else begin : g_mid_l
      assign left_w = cell_q[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_w = ctrl_i.data;
    end else begin : g_mid_r
      assign right_w = cell_q[k+1];
    end

    olist_cell #(
      .INDEX (k),
      .IW    (IW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (idx_i),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_q[k])
    );
  end

  assign head_o = cell_q[0];

endmodule

// ===== sv/ordered_list_engine_top.sv =====
// Ordered list engine: a bounded list of signed 32-bit values in a row of cells.
// Input channel in_valid_i / in_stall_o / in_item_i carries one request per item:
// insert at a 1-based position, find the first equal value, or delete a range.
// Output channel out_valid_o / out_stall_i / out_item_o returns one result item
// per request: found position (finds only) and a status code.
// An insert or an unused code finishes in S_EXEC; a find or a range delete then
// scans every list entry in S_SCAN. One item is in work at a time and the input
// reopens in the cycle after the result is loaded.
// Finds and deletes rotate the list one entry per cycle through the head cell,
// where the compare happens; inserts shift all later cells back together.
// Reset empties the list (length zero); cell contents are not cleared.
// The result waits in an output register while out_stall_i is high. The next
// item is still accepted meanwhile, and its work runs, but its result is held
// until the register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ordered_list_engine_top #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  olist_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output olist_pkg::out_item_t out_item_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((LW > olist_pkg::POS_W) ? LW : olist_pkg::POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                          state_q;
  olist_pkg::in_item_t             req_q;
  logic [LW-1:0]                   length_q;
  logic [LW-1:0]                   ring_q;
  logic [LW-1:0]                   cnt_q;
  logic [LW-1:0]                   scan_len_q;
  logic                            hit_q;
  logic [olist_pkg::POS_W-1:0]     found_q;
  logic [olist_pkg::STAT_W-1:0]    status_q;
  logic                            out_valid_q;
  olist_pkg::out_item_t            out_item_q;

  olist_pkg::cell_ctrl_t           cell_ctrl;
  logic [IW-1:0]                   cell_idx;
  logic [olist_pkg::DATA_W-1:0]    head;

  logic                            is_full;
  logic                            is_beyond;
  logic                            insert_ok;
  logic [IW-1:0]                   insert_at;
  logic                            scan_active;
  logic                            head_match;
  logic                            head_in_range;
  logic                            out_free;

  // insert checks: full before position
  assign is_full   = length_q == LW'(CAPACITY);
  assign is_beyond = CW'(req_q.position) > (CW'(length_q) + CW'(1));
  assign insert_ok = (req_q.req_type == olist_pkg::REQ_INSERT) && !is_full && !is_beyond;
  assign insert_at = (req_q.position == '0) ? '0 :
                     IW'(req_q.position - olist_pkg::POS_W'(1));

  // head cell compares
  assign scan_active   = (state_q == S_SCAN) && (cnt_q != scan_len_q);
  assign head_match    = head == req_q.value;
  assign head_in_range = ($signed(head) >= req_q.value) && ($signed(head) <= req_q.upper_bound);

  assign out_free = !out_valid_q || !out_stall_i;

  // drive the cell row: shift back on insert, rotate within the ring on a scan
  always_comb begin
    cell_ctrl.mode = olist_pkg::CELL_HOLD;
    cell_ctrl.data = head;
    cell_idx       = '0;
    if (state_q == S_EXEC && insert_ok) begin
      cell_ctrl.mode = olist_pkg::CELL_RIGHT;
      cell_ctrl.data = req_q.value;
      cell_idx       = insert_at;
    end else if (scan_active) begin
      cell_ctrl.mode = olist_pkg::CELL_LEFT;
      cell_idx       = IW'(ring_q - LW'(1));
    end
  end

  olist_chain #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_chain (
    .clk_i  (clk_i),
    .ctrl_i (cell_ctrl),
    .idx_i  (cell_idx),
    .head_o (head)
  );

  // sequencer, list length and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      length_q    <= '0;
      ring_q      <= '0;
      cnt_q       <= '0;
      scan_len_q  <= '0;
      hit_q       <= 1'b0;
      found_q     <= '0;
      status_q    <= olist_pkg::ST_OK;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      // drop the result once taken, unless a new one loads now
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_item_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          found_q <= '0;
          unique case (req_q.req_type) inside
            olist_pkg::REQ_INSERT: begin
              if (is_full) begin
                status_q <= olist_pkg::ST_FULL;
              end else if (is_beyond) begin
                status_q <= olist_pkg::ST_BEYOND;
              end else begin
                status_q <= olist_pkg::ST_OK;
                length_q <= length_q + LW'(1);
              end
              state_q <= S_DONE;
            end
            olist_pkg::REQ_FIND, olist_pkg::REQ_DELETE: begin
              status_q   <= olist_pkg::ST_OK;
              cnt_q      <= '0;
              scan_len_q <= length_q;
              ring_q     <= length_q;
              hit_q      <= 1'b0;
              state_q    <= S_SCAN;
            end
            default: begin
              status_q <= olist_pkg::ST_OK;
              state_q  <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          if (cnt_q == scan_len_q) begin
            if (req_q.req_type == olist_pkg::REQ_DELETE) begin
              length_q <= ring_q;
            end
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q + LW'(1);
            if (req_q.req_type == olist_pkg::REQ_FIND) begin
              if (!hit_q && head_match) begin
                hit_q   <= 1'b1;
                found_q <= olist_pkg::POS_W'(cnt_q + LW'(1));
              end
            end else if (head_in_range) begin
              // remove the head entry: ring shrinks by one
              ring_q <= ring_q - LW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_item_q.found_position <= found_q;
            out_item_q.status         <= status_q;
            out_valid_q               <= 1'b1;
            state_q                   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `OLE_ASSERT(a_length_bound, length_q <= LW'(CAPACITY))
  `OLE_ASSERT_IMPL(a_scan_bounds, state_q == S_SCAN, (cnt_q <= scan_len_q) && (ring_q <= scan_len_q))
  `OLE_ASSERT_IMPL(a_found_ok, out_valid_o && (out_item_o.found_position != '0), out_item_o.status == olist_pkg::ST_OK)
  `OLE_ASSERT_IMPL(a_hold_result, (state_q == S_DONE) && !out_free, ##1 (state_q == S_DONE) || (state_q == S_IDLE))

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import olist_pkg::*;

  localparam int unsigned LIST_CAP       = 1024;
  localparam int unsigned MAX_POS        = 1025;
  localparam int unsigned RAND_ITEMS     = 290;
  localparam int unsigned FILL_AT        = 140;
  localparam int unsigned QUIET_ITEMS    = 60;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned POOL_N         = 12;
  localparam int unsigned WATCHDOG_LIMIT = 12000;
  localparam int unsigned SETTLE_CYCLES  = LIST_CAP + 16;

  // request code the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] VAL_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_ABSENT = VAL_MIN + 1;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  in_item_t                 pending_q[$];
  out_item_t                expected_q[$];
  logic signed [DATA_W-1:0] shadow_list[$];
  logic signed [DATA_W-1:0] value_pool[POOL_N];

  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count  = 0;
  logic        quiet       = 1'b0;
  logic        hold_req    = 1'b0;
  logic        hold_done   = 1'b0;

  ordered_list_engine_top #(
    .CAPACITY(LIST_CAP)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Apply one request to the shadow list and return the result it gives
  function automatic out_item_t list_apply(in_item_t req);
    out_item_t                res;
    int unsigned              at;
    logic signed [DATA_W-1:0] kept[$];
    res = '0;
    case (req.req_type)
      REQ_INSERT: begin
        // full is checked before the position
        if (shadow_list.size() >= LIST_CAP) begin
          res.status = ST_FULL;
        end else if (req.position > shadow_list.size() + 1) begin
          res.status = ST_BEYOND;
        end else begin
          at = (req.position == 0) ? 0 : req.position - 1;
          shadow_list.insert(at, req.value);
        end
      end
      REQ_FIND: begin
        for (int k = 0; k < shadow_list.size(); k++) begin
          if (shadow_list[k] == req.value) begin
            res.found_position = POS_W'(k + 1);
            break;
          end
        end
      end
      REQ_DELETE: begin
        // keep what lies outside the inclusive signed range
        foreach (shadow_list[k]) begin
          if (!(shadow_list[k] >= req.value && shadow_list[k] <= req.upper_bound)) begin
            kept.push_back(shadow_list[k]);
          end
        end
        shadow_list = kept;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void offer(logic [REQ_W-1:0] kind, int unsigned pos,
                                logic signed [DATA_W-1:0] val,
                                logic signed [DATA_W-1:0] ub);
    in_item_t r;
    r.req_type    = kind;
    r.position    = POS_W'(pos);
    r.value       = val;
    r.upper_bound = ub;
    pending_q.push_back(r);
  endfunction

  // Mostly values from a small pool so that finds and deletes hit
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 6) begin
      return value_pool[$urandom_range(0, POOL_N - 1)];
    end
    return $urandom;
  endfunction

  function automatic in_item_t random_request(int unsigned cur_len);
    in_item_t    r;
    int unsigned pick;
    int unsigned sel;
    r.req_type    = REQ_FIND;
    r.position    = POS_W'($urandom_range(0, MAX_POS));
    r.value       = pick_value();
    r.upper_bound = $urandom;
    pick          = $urandom_range(0, 99);
    if (pick < 55) begin
      r.req_type = REQ_INSERT;
      if (pick < 50) begin
        r.position = POS_W'($urandom_range(0, cur_len + 1));
      end else if (cur_len + 2 <= MAX_POS) begin
        r.position = POS_W'($urandom_range(cur_len + 2, MAX_POS));
      end
    end else if (pick < 80) begin
      r.req_type = REQ_FIND;
    end else if (pick < 98) begin
      r.req_type = REQ_DELETE;
      sel        = $urandom_range(0, 19);
      if (sel < 11) begin
        r.upper_bound = r.value;
      end else if (sel < 15) begin
        r.upper_bound = r.value + $urandom_range(0, 64);
      end else if (sel < 19) begin
        r.upper_bound = pick_value();
      end else begin
        r.value       = VAL_MIN;
        r.upper_bound = VAL_MAX;
      end
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  // Offer items from the pending queue; predict each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic slot_free;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      slot_free = !in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(list_apply(in_item_i));
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (pending_q.size() != 0) begin
          in_item_i  <= pending_q.pop_front();
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 4) == 0) begin
            send_gap <= $urandom_range(1, 5);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check each accepted result against the oldest prediction; drive stall
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected: found_position %0d status %0d",
                   $time, out_item_o.found_position, out_item_o.status);
        end else begin
          want = expected_q.pop_front();
          if (out_item_o.found_position !== want.found_position) begin
            fail_count++;
            $display("%0t: found_position expected %0d actual %0d",
                     $time, want.found_position, out_item_o.found_position);
          end
          if (out_item_o.status !== want.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_item_o.status);
          end
        end
      end
      // hold off once for a long stretch, otherwise stall in short bursts
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        hold_left   <= LONG_HOLD - 1;
        hold_done   <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 4);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_test
    logic signed [DATA_W-1:0] fill_val;
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (int k = 5; k < POOL_N; k++) begin
      value_pool[k] = $urandom;
    end

    // directed: empty list, ends of the list, extremes, unused code, ranges
    offer(REQ_FIND,   0,       5,       0);
    offer(REQ_DELETE, 0,       VAL_MIN, VAL_MAX);
    offer(REQ_INSERT, 2,       7,       0);
    offer(REQ_INSERT, MAX_POS, 7,       0);
    offer(REQ_INSERT, 0,       VAL_MAX, 0);
    offer(REQ_INSERT, 1,       VAL_MIN, 0);
    offer(REQ_INSERT, 3,       0,       0);
    offer(REQ_INSERT, 2,       -1,      0);
    offer(REQ_INSERT, 1023,    9,       -1);
    offer(REQ_INSERT, 1024,    9,       -1);
    offer(REQ_FIND,   MAX_POS, VAL_MAX, -1);
    offer(REQ_FIND,   0,       VAL_MIN, 0);
    offer(REQ_FIND,   0,       0,       0);
    offer(REQ_FIND,   0,       12345,   0);
    offer(REQ_UNUSED, MAX_POS, -1,      -1);
    offer(REQ_INSERT, 2,       -1,      0);
    offer(REQ_FIND,   0,       -1,      0);
    offer(REQ_DELETE, 0,       VAL_MAX, VAL_MIN);
    offer(REQ_DELETE, 0,       -1,      -1);
    offer(REQ_DELETE, 0,       VAL_MIN, VAL_MIN);
    offer(REQ_DELETE, 0,       0,       VAL_MAX);
    offer(REQ_FIND,   0,       0,       0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < RAND_ITEMS; n++) begin
      while (pending_q.size() >= 3) @(posedge clk_i);
      if (n == RAND_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
      // fill to capacity behind a long output hold-off, then hit the full list
      if (n == FILL_AT) begin
        hold_req <= 1'b1;
        offer(REQ_DELETE, 0, VAL_MIN, VAL_MAX);
        for (int k = 0; k < LIST_CAP - 1; k++) begin
          do begin
            fill_val = $urandom;
          end while (fill_val == VAL_MIN || fill_val == VAL_ABSENT);
          offer(REQ_INSERT, $urandom_range(0, k + 1), fill_val, $urandom);
        end
        offer(REQ_INSERT, LIST_CAP, VAL_MIN, 0);
        offer(REQ_INSERT, 0, 1, 0);
        offer(REQ_INSERT, MAX_POS, 1, 0);
        offer(REQ_FIND, 0, VAL_MIN, 0);
        offer(REQ_FIND, 0, VAL_ABSENT, 0);
        offer(REQ_DELETE, 0, VAL_MIN, VAL_MAX);
      end
      pending_q.push_back(random_request(shadow_list.size()));
    end

    // drain, then give any stray result time to show up
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/olist_pkg.sv
sv/olist_cell.sv
sv/olist_chain.sv
sv/ordered_list_engine_top.sv
tb/sv/tb.sv
